@@ rtl/drrip_pkg.sv @@
// shared types, constants and helper functions of the drrip replacement block
package drrip_pkg;

    localparam int NUM_SETS      = 2048;
    localparam int NUM_WAYS      = 16;
    localparam int NUM_LEADERS   = 64;
    localparam int SELECTOR_BITS = 10;

    localparam int SET_BITS    = $clog2(NUM_SETS);
    localparam int WAY_BITS    = $clog2(NUM_WAYS);
    localparam int DRAW_BITS   = 7;
    localparam int PERIOD_BITS = 20;
    localparam int PCT_BITS    = 7;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 20;

    localparam int LEADER_STRIDE = NUM_SETS / NUM_LEADERS;
    localparam int STRIDE_BITS   = $clog2(LEADER_STRIDE);

    // one memory row per set: re-reference values low, dead counters high
    localparam int HALF_W = 2 * NUM_WAYS;
    localparam int ROW_W  = 2 * HALF_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);

    localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};
    localparam logic [SELECTOR_BITS-1:0] SEL_MID = {1'b1, {(SELECTOR_BITS-1){1'b0}}};

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(100000);
    localparam logic [PCT_BITS-1:0]    PCT_RESET    = PCT_BITS'(5);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_PERIOD = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIMODAL_PCT  = 1'b1;

    // request types
    localparam logic REQ_VICTIM = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // set kinds for set dueling
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_FOLLOW = 2'd0;
    localparam t_kind KIND_SRRIP  = 2'd1;
    localparam t_kind KIND_BRRIP  = 2'd2;

    // item as it travels from front to back
    typedef struct packed {
        logic                 req_type;
        logic [SET_BITS-1:0]  set_idx;
        logic [WAY_BITS-1:0]  way_idx;
        logic                 was_hit;
        logic [DRAW_BITS-1:0] draw;
        t_kind                kind;
    } t_item;

    // queue handshake between front and back
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    // leader classification of a set
    function automatic t_kind leader_kind(input logic [SET_BITS-1:0] s);
        logic [SET_BITS-1:0] idx;
        t_kind               k;
        idx = s >> STRIDE_BITS;
        k   = KIND_FOLLOW;
        if ((s & SET_BITS'(LEADER_STRIDE - 1)) == '0) begin
            if (idx < SET_BITS'(NUM_LEADERS / 2)) begin
                k = KIND_SRRIP;
            end else if (idx < SET_BITS'(NUM_LEADERS)) begin
                k = KIND_BRRIP;
            end
        end
        return k;
    endfunction

endpackage

@@ rtl/drrip_dead_block_replacement.sv @@
// top level of the drrip replacement policy with dead-block approximation
// each item is one read-modify-write of its per-set row: queued, read in S_IDLE,
// written back in S_EXEC with the result strobe; no new item is popped before it
// an update that triggers decay adds a sweep over all sets
// reset: a clearing pass writes every row with busy held high;
//   configuration writes are taken throughout, results cannot be held off
module drrip_dead_block_replacement (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_req_type,
    input  logic [drrip_pkg::SET_BITS-1:0]      i_set_index,
    input  logic [drrip_pkg::WAY_BITS-1:0]      i_way_index,
    input  logic                                i_was_hit,
    input  logic [drrip_pkg::DRAW_BITS-1:0]     i_bimodal_draw,
    output logic                                o_valid,
    output logic [drrip_pkg::WAY_BITS-1:0]      o_victim_way,
    output logic [drrip_pkg::SELECTOR_BITS-1:0] o_selector_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [drrip_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [drrip_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import drrip_pkg::*;

    t_queue_out queue;
    t_back_ctl  back_ctl;

    assign o_cfg_ready = 1'b1;

    drrip_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_set_index   (i_set_index),
        .i_way_index   (i_way_index),
        .i_was_hit     (i_was_hit),
        .i_bimodal_draw(i_bimodal_draw),
        .i_back_ctl    (back_ctl),
        .o_queue       (queue)
    );

    drrip_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_queue         (queue),
        .o_back_ctl      (back_ctl),
        .o_valid         (o_valid),
        .o_victim_way    (o_victim_way),
        .o_selector_value(o_selector_value)
    );

    // no result while the clearing pass runs
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_ctl.clearing |-> !o_valid)
        else $error("result during clearing pass");

    // results never come in consecutive cycles
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    // the selector moves only with a result
    a_selector_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (o_selector_value != $past(o_selector_value))) |-> o_valid)
        else $error("selector changed without a result");

    // the back end pops only when the queue holds an item
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_ctl.pop |-> queue.valid)
        else $error("pop from empty queue");

endmodule

@@ rtl/drrip_ram.sv @@
// generic simple dual-port ram with registered read
module drrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/drrip_front.sv @@
// front end: takes items, classifies the set and queues them for the back end
module drrip_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_req_type,
    input  logic [drrip_pkg::SET_BITS-1:0]  i_set_index,
    input  logic [drrip_pkg::WAY_BITS-1:0]  i_way_index,
    input  logic                            i_was_hit,
    input  logic [drrip_pkg::DRAW_BITS-1:0] i_bimodal_draw,
    input  drrip_pkg::t_back_ctl            i_back_ctl,
    output drrip_pkg::t_queue_out           o_queue
);
    import drrip_pkg::*;

    t_item                 r_q [QUEUE_DEPTH];
    logic [QUEUE_BITS-1:0] r_rd, r_wr;
    logic [QUEUE_BITS:0]   r_cnt;
    logic                  push, pop;
    t_item                 new_item;

    // classify the incoming item
    always_comb begin
        new_item.req_type = i_req_type;
        new_item.set_idx  = i_set_index;
        new_item.way_idx  = i_way_index;
        new_item.was_hit  = i_was_hit;
        new_item.draw     = i_bimodal_draw;
        new_item.kind     = leader_kind(i_set_index);
    end

    assign busy = (r_cnt == (QUEUE_BITS+1)'(QUEUE_DEPTH)) || i_back_ctl.clearing;
    assign push = start && !busy;
    assign pop  = i_back_ctl.pop && (r_cnt != '0);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= new_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_queue.valid = (r_cnt != '0);
    assign o_queue.item  = r_q[r_rd];

endmodule

@@ rtl/drrip_back.sv @@
// back end: clears the line state, runs victim and update items, sweeps decay
module drrip_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [drrip_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [drrip_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  drrip_pkg::t_queue_out               i_queue,
    output drrip_pkg::t_back_ctl                o_back_ctl,
    output logic                                o_valid,
    output logic [drrip_pkg::WAY_BITS-1:0]      o_victim_way,
    output logic [drrip_pkg::SELECTOR_BITS-1:0] o_selector_value
);
    import drrip_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    logic [1:0]               r_state, n_state;
    t_item                    r_item, n_item;
    logic [SET_BITS:0]        r_ptr, n_ptr;
    logic                     r_wv, n_wv;
    logic [SET_BITS-1:0]      r_wa, n_wa;
    logic [PERIOD_BITS-1:0]   r_tick, n_tick;
    logic [PERIOD_BITS-1:0]   r_period;
    logic [PCT_BITS-1:0]      r_pct;
    logic [SELECTOR_BITS-1:0] r_sel, n_sel;
    logic                     r_out_valid, n_out_valid;
    logic [WAY_BITS-1:0]      r_out_victim, n_out_victim;

    logic                     we, re;
    logic [SET_BITS-1:0]      waddr, raddr;
    logic [ROW_W-1:0]         wdata, rdata;

    logic [1:0]               rr [NUM_WAYS];
    logic [1:0]               dd [NUM_WAYS];
    logic [1:0]               rv [NUM_WAYS];
    logic [1:0]               ru [NUM_WAYS];
    logic [1:0]               du [NUM_WAYS];
    logic                     any3, any2, any1;
    logic [1:0]               age;
    logic [WAY_BITS-1:0]      vic;
    logic [1:0]               dn;
    logic [PERIOD_BITS-1:0]   tick_inc;
    logic                     fire;
    logic [1:0]               bim;
    logic [1:0]               ins;
    logic [SELECTOR_BITS-1:0] sel_upd;
    logic [ROW_W-1:0]         row_vic, row_upd, row_dec, row_clr;

    drrip_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NUM_SETS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // cleared row: every re-reference value 3, every dead counter 0
    always_comb begin
        row_clr = '0;
        row_clr[HALF_W-1:0] = {HALF_W{1'b1}};
    end

    // split the row read for the current item
    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            rr[i] = rdata[2*i +: 2];
            dd[i] = rdata[HALF_W + 2*i +: 2];
        end
    end

    // victim: age the set until one way reaches 3, pick the lowest such way
    always_comb begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            any3 = any3 | (rr[i] == 2'd3);
            any2 = any2 | (rr[i] == 2'd2);
            any1 = any1 | (rr[i] == 2'd1);
        end
        if (any3) begin
            age = 2'd0;
        end else if (any2) begin
            age = 2'd1;
        end else if (any1) begin
            age = 2'd2;
        end else begin
            age = 2'd3;
        end
        vic = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            rv[i] = rr[i] + age;
            if (rv[i] == 2'd3) begin
                vic = WAY_BITS'(i);
            end
        end
        row_vic = rdata;
        for (int i = 0; i < NUM_WAYS; i++) begin
            row_vic[2*i +: 2] = rv[i];
        end
    end

    // update: dead counter, decay, selector and insertion
    always_comb begin
        if (r_item.was_hit) begin
            dn = 2'd0;
        end else if (dd[r_item.way_idx] == 2'd3) begin
            dn = 2'd3;
        end else begin
            dn = dd[r_item.way_idx] + 2'd1;
        end
        tick_inc = r_tick + 1'b1;
        fire     = (tick_inc >= r_period);
        for (int i = 0; i < NUM_WAYS; i++) begin
            du[i] = (WAY_BITS'(i) == r_item.way_idx) ? dn : dd[i];
            if (fire && du[i] != 2'd0) begin
                du[i] = du[i] - 2'd1;
            end
            ru[i] = rr[i];
        end
        sel_upd = r_sel;
        if (!r_item.was_hit) begin
            if (r_item.kind == KIND_SRRIP && r_sel != SEL_MAX) begin
                sel_upd = r_sel + 1'b1;
            end else if (r_item.kind == KIND_BRRIP && r_sel != '0) begin
                sel_upd = r_sel - 1'b1;
            end
        end
        bim = ({1'b0, r_item.draw} < {1'b0, r_pct}) ? 2'd2 : 2'd3;
        if (du[r_item.way_idx] == 2'd3) begin
            ins = 2'd3;
        end else if (r_item.kind == KIND_SRRIP) begin
            ins = 2'd2;
        end else if (r_item.kind == KIND_BRRIP) begin
            ins = bim;
        end else if (sel_upd >= SEL_MID) begin
            ins = bim;
        end else begin
            ins = 2'd2;
        end
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (WAY_BITS'(i) == r_item.way_idx) begin
                ru[i] = r_item.was_hit ? 2'd0 : ins;
            end
        end
        for (int i = 0; i < NUM_WAYS; i++) begin
            row_upd[2*i +: 2]          = ru[i];
            row_upd[HALF_W + 2*i +: 2] = du[i];
        end
    end

    // decay of one swept row
    always_comb begin
        row_dec = rdata;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (dd[i] != 2'd0) begin
                row_dec[HALF_W + 2*i +: 2] = dd[i] - 2'd1;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_ptr        = r_ptr;
        n_wv         = 1'b0;
        n_wa         = r_wa;
        n_tick       = r_tick;
        n_sel        = r_sel;
        n_out_valid  = 1'b0;
        n_out_victim = r_out_victim;
        we           = 1'b0;
        waddr        = r_wa;
        wdata        = row_dec;
        re           = 1'b0;
        raddr        = i_queue.item.set_idx;
        o_back_ctl.pop      = 1'b0;
        o_back_ctl.clearing = (r_state == S_CLEAR);
        case (r_state)
            S_CLEAR: begin
                we    = !r_ptr[SET_BITS];
                waddr = r_ptr[SET_BITS-1:0];
                wdata = row_clr;
                if (r_ptr[SET_BITS]) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_queue.valid) begin
                    o_back_ctl.pop = 1'b1;
                    re      = 1'b1;
                    n_item  = i_queue.item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                we          = 1'b1;
                waddr       = r_item.set_idx;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
                if (r_item.req_type == REQ_VICTIM) begin
                    wdata        = row_vic;
                    n_out_victim = vic;
                end else begin
                    wdata        = row_upd;
                    n_out_victim = '0;
                    n_sel        = sel_upd;
                    n_tick       = tick_inc;
                    if (fire) begin
                        n_tick  = '0;
                        n_ptr   = '0;
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                // read one row, write back the row read in the previous cycle
                re    = !r_ptr[SET_BITS];
                raddr = r_ptr[SET_BITS-1:0];
                we    = r_wv && (r_wa != r_item.set_idx);
                n_wv  = !r_ptr[SET_BITS];
                n_wa  = r_ptr[SET_BITS-1:0];
                if (!r_ptr[SET_BITS]) begin
                    n_ptr = r_ptr + 1'b1;
                end else if (!r_wv) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_wv        <= 1'b0;
            r_tick      <= '0;
            r_sel       <= SEL_MID;
            r_out_valid <= 1'b0;
            r_period    <= PERIOD_RESET;
            r_pct       <= PCT_RESET;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_wv        <= n_wv;
            r_tick      <= n_tick;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DECAY_PERIOD: r_period <= i_cfg_data[PERIOD_BITS-1:0];
                    CFG_BIMODAL_PCT:  r_pct    <= i_cfg_data[PCT_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_wa         <= n_wa;
        r_out_victim <= n_out_victim;
    end

    assign o_valid          = r_out_valid;
    assign o_victim_way     = r_out_victim;
    assign o_selector_value = r_sel;

endmodule

@@ tb/tb_drrip_dead_block_replacement.sv @@
// testbench of the drrip dead-block replacement policy, checked against a predictor
module tb_drrip_dead_block_replacement;
    timeunit 1ns;
    timeprecision 1ps;
    import drrip_pkg::*;

    // one row of directed stimulus, with typed-in results where obvious
    typedef struct {
        logic                 req;
        int                   set_i;
        int                   way_i;
        logic                 hit;
        int                   draw;
        bit                   typed;
        int                   t_victim;
        int                   t_sel;
    } t_row;

    typedef struct {
        logic [WAY_BITS-1:0]      victim;
        logic [SELECTOR_BITS-1:0] sel;
    } t_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_req_type = REQ_VICTIM;
    logic [SET_BITS-1:0]      i_set_index = '0;
    logic [WAY_BITS-1:0]      i_way_index = '0;
    logic                     i_was_hit = 1'b0;
    logic [DRAW_BITS-1:0]     i_bimodal_draw = '0;
    logic                     o_valid;
    logic [WAY_BITS-1:0]      o_victim_way;
    logic [SELECTOR_BITS-1:0] o_selector_value;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // predictor state
    logic [1:0]               rrpv [NUM_SETS][NUM_WAYS];
    logic [1:0]               dead [NUM_SETS][NUM_WAYS];
    logic [SELECTOR_BITS-1:0] duel_sel;
    logic [PERIOD_BITS-1:0]   tick;
    logic [PERIOD_BITS-1:0]   period;
    logic [PCT_BITS-1:0]      pct;

    t_result pending_results[$];
    int      errors = 0;
    bit      fast_phase;

    drrip_dead_block_replacement u_dut (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #40_000_000;
        $display("tb_drrip_dead_block_replacement NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // set classification for dueling
    function automatic t_kind set_kind(input int s);
        if (s % LEADER_STRIDE != 0 || s / LEADER_STRIDE >= NUM_LEADERS) return KIND_FOLLOW;
        return (s / LEADER_STRIDE < NUM_LEADERS / 2) ? KIND_SRRIP : KIND_BRRIP;
    endfunction

    function automatic logic [1:0] bimodal_rrpv(input int draw);
        return (draw < pct) ? 2'd2 : 2'd3;
    endfunction

    // replacement policy step: victim choice or post-access update
    function automatic t_result predict_step(input logic req, input int s, input int w,
                                             input logic hit, input int draw);
        t_result    r;
        logic [1:0] top;
        t_kind      k;
        r.victim = '0;
        if (req == REQ_VICTIM) begin
            top = 2'd0;
            for (int i = 0; i < NUM_WAYS; i++) if (rrpv[s][i] > top) top = rrpv[s][i];
            for (int i = 0; i < NUM_WAYS; i++) rrpv[s][i] = rrpv[s][i] + (2'd3 - top);
            for (int i = NUM_WAYS - 1; i >= 0; i--)
                if (rrpv[s][i] == 2'd3) r.victim = WAY_BITS'(i);
        end else begin
            k = set_kind(s);
            if (hit) begin
                dead[s][w] = 2'd0;
                rrpv[s][w] = 2'd0;
            end else if (dead[s][w] != 2'd3) begin
                dead[s][w]++;
            end
            tick = tick + 1'b1;
            if (tick >= period) begin
                tick = '0;
                for (int a = 0; a < NUM_SETS; a++)
                    for (int b = 0; b < NUM_WAYS; b++)
                        if (dead[a][b] != 2'd0) dead[a][b]--;
            end
            if (!hit) begin
                if (k == KIND_SRRIP && duel_sel != SEL_MAX) duel_sel++;
                else if (k == KIND_BRRIP && duel_sel != '0) duel_sel--;
                if (dead[s][w] == 2'd3) rrpv[s][w] = 2'd3;
                else if (k == KIND_SRRIP) rrpv[s][w] = 2'd2;
                else if (k == KIND_BRRIP) rrpv[s][w] = bimodal_rrpv(draw);
                else if (duel_sel >= SEL_MID) rrpv[s][w] = bimodal_rrpv(draw);
                else rrpv[s][w] = 2'd2;
            end
        end
        r.sel = duel_sel;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, victim", o_victim_way, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_victim_way !== want.victim)
                    report_mismatch("victim_way", o_victim_way, want.victim);
                if (o_selector_value !== want.sel)
                    report_mismatch("selector_value", o_selector_value, want.sel);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_DATA_BITS'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DECAY_PERIOD) period = PERIOD_BITS'(data);
        else pct = PCT_BITS'(data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // drive one item and hold it until accepted; typed results override the predictor
    task automatic send_item(input logic req, input int s, input int w, input logic hit,
                             input int draw, input bit typed, input int tv, input int ts);
        t_result r;
        int      gap;
        gap = $urandom_range(0, 9);
        if (!fast_phase && gap >= 7) begin
            start = 1'b0;
            repeat (gap == 9 ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(negedge i_clk);
        end
        start          = 1'b1;
        i_req_type     = req;
        i_set_index    = SET_BITS'(s);
        i_way_index    = WAY_BITS'(w);
        i_was_hit      = hit;
        i_bimodal_draw = DRAW_BITS'(draw);
        do @(posedge i_clk); while (busy);
        r = predict_step(req, s, w, hit, draw);
        if (typed) begin
            r.victim = WAY_BITS'(tv);
            r.sel    = SELECTOR_BITS'(ts);
        end
        pending_results.push_back(r);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // hold off until every result is back and any decay sweep is over
    task automatic drain();
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NUM_SETS + 40) @(posedge i_clk);
    endtask

    // set choice biased toward leaders and a few hot followers
    function automatic int pick_set();
        int leaders [6] = '{0, 32, 992, 1024, 1056, 2016};
        int hot     [5] = '{1, 2, 33, 1500, 2047};
        int p;
        p = $urandom_range(0, 9);
        if (p < 4) return leaders[$urandom_range(0, 5)];
        if (p < 8) return hot[$urandom_range(0, 4)];
        return $urandom_range(0, NUM_SETS - 1);
    endfunction

    initial begin
        t_row rows[$];
        int   periods[7] = '{1048575, 1, 0, 5, 40, 100000, 3};
        int   pcts   [7] = '{0, 127, 100, 50, 5, 100, 30};
        int   counts [7] = '{90, 20, 10, 120, 150, 80, 80};

        for (int a = 0; a < NUM_SETS; a++)
            for (int b = 0; b < NUM_WAYS; b++) begin
                rrpv[a][b] = 2'd3;
                dead[a][b] = 2'd0;
            end
        duel_sel = SEL_MID;
        tick     = '0;
        period   = PERIOD_RESET;
        pct      = PCT_RESET;

        // directed rows: extremes, hits, misses in every set kind, dead saturation
        rows = '{
            '{REQ_VICTIM, 5,    15, 1, 127, 1, 0, 512},
            '{REQ_UPDATE, 0,    0,  0, 0,   1, 0, 513},
            '{REQ_UPDATE, 1024, 0,  0, 0,   1, 0, 512},
            '{REQ_VICTIM, 2047, 0,  0, 0,   0, 0, 0},
            '{REQ_UPDATE, 2047, 15, 1, 127, 0, 0, 0},
            '{REQ_UPDATE, 2047, 0,  1, 0,   0, 0, 0},
            '{REQ_VICTIM, 2047, 0,  0, 0,   0, 0, 0},
            '{REQ_UPDATE, 7,    3,  0, 0,   0, 0, 0},
            '{REQ_UPDATE, 7,    3,  0, 99,  0, 0, 0},
            '{REQ_UPDATE, 7,    3,  0, 4,   0, 0, 0},
            '{REQ_UPDATE, 7,    3,  0, 4,   0, 0, 0},
            '{REQ_VICTIM, 7,    0,  0, 0,   0, 0, 0},
            '{REQ_UPDATE, 2016, 9,  0, 0,   0, 0, 0},
            '{REQ_UPDATE, 992,  9,  0, 127, 0, 0, 0},
            '{REQ_UPDATE, 33,   5,  0, 2,   0, 0, 0},
            '{REQ_UPDATE, 33,   6,  1, 2,   0, 0, 0},
            '{REQ_VICTIM, 33,   0,  0, 0,   0, 0, 0},
            '{REQ_UPDATE, 2016, 9,  0, 0,   0, 0, 0},
            '{REQ_UPDATE, 2016, 9,  0, 0,   0, 0, 0},
            '{REQ_VICTIM, 2016, 0,  0, 0,   0, 0, 0}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        fast_phase = 1'b0;
        foreach (rows[i])
            send_item(rows[i].req, rows[i].set_i, rows[i].way_i, rows[i].hit, rows[i].draw,
                      rows[i].typed, rows[i].t_victim, rows[i].t_sel);

        // random phases under different register settings
        for (int ph = 0; ph < 7; ph++) begin
            drain();
            write_reg(CFG_DECAY_PERIOD, periods[ph]);
            write_reg(CFG_BIMODAL_PCT, pcts[ph]);
            fast_phase = (ph % 3 == 1);
            for (int n = 0; n < counts[ph]; n++)
                send_item($urandom_range(0, 99) < 55 ? REQ_UPDATE : REQ_VICTIM, pick_set(),
                          $urandom_range(0, 15), $urandom_range(0, 1),
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                    : $urandom_range(0, 99),
                          1'b0, 0, 0);
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_drrip_dead_block_replacement OK");
        end else begin
            $display("tb_drrip_dead_block_replacement NOT OK");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/drrip_pkg.sv
rtl/drrip_ram.sv
rtl/drrip_front.sv
rtl/drrip_back.sv
rtl/drrip_dead_block_replacement.sv
tb/tb_drrip_dead_block_replacement.sv
